@@ hw/rtl/ltc_pkg.sv @@
package ltc_pkg;

    // Fixed-point format and table geometry.
    localparam int FRAC_BITS     = 16;
    localparam int CURVE_ENTRIES = 256;
    localparam int CURVE_AW      = $clog2(CURVE_ENTRIES);
    localparam int PIX_W         = 8;
    localparam int CV_W          = 9;
    localparam int TUNE_W        = 9;
    localparam int COEF_W        = FRAC_BITS + 1;

    // Datapath widths.
    localparam int Y_W   = PIX_W + FRAC_BITS;
    localparam int C_W   = PIX_W + FRAC_BITS + 1;
    localparam int YC_W  = CV_W + FRAC_BITS;
    localparam int A_W   = YC_W - 6;
    localparam int REM_W = 7;
    localparam int AT_W  = A_W + TUNE_W;
    localparam int BT_W  = REM_W + TUNE_W;
    localparam int Q2_W  = BT_W - 6;
    localparam int YS_W  = AT_W + 1;

    // Division by 100 as a multiply by a rounded-up reciprocal.
    localparam int DIV1_SHIFT = YC_W + 7;
    localparam int M1_W       = DIV1_SHIFT - 6;
    localparam logic [M1_W-1:0] DIV1_MUL = M1_W'(((64'd1 << DIV1_SHIFT) + 64'd99) / 64'd100);
    localparam int DIV2_SHIFT = BT_W + 7;
    localparam int M2_W       = DIV2_SHIFT - 6;
    localparam logic [M2_W-1:0] DIV2_MUL = M2_W'(((64'd1 << DIV2_SHIFT) + 64'd99) / 64'd100);

    localparam logic [Y_W-1:0] Y_MAX = Y_W'(64'd255 << FRAC_BITS);

    // Color coefficients, rounded from millionths.
    localparam longint MICRO = 1000000;
    localparam logic [COEF_W-1:0] CF_Y_R  =
        COEF_W'(((longint'(299000) << FRAC_BITS) + MICRO / 2) / MICRO);
    localparam logic [COEF_W-1:0] CF_Y_G  =
        COEF_W'(((longint'(587000) << FRAC_BITS) + MICRO / 2) / MICRO);
    localparam logic [COEF_W-1:0] CF_Y_B  =
        COEF_W'(((longint'(114000) << FRAC_BITS) + MICRO / 2) / MICRO);
    localparam logic [COEF_W-1:0] CF_CB_R =
        COEF_W'(((longint'(168736) << FRAC_BITS) + MICRO / 2) / MICRO);
    localparam logic [COEF_W-1:0] CF_CB_G =
        COEF_W'(((longint'(331264) << FRAC_BITS) + MICRO / 2) / MICRO);
    localparam logic [COEF_W-1:0] CF_HALF =
        COEF_W'(((longint'(500000) << FRAC_BITS) + MICRO / 2) / MICRO);
    localparam logic [COEF_W-1:0] CF_CR_G =
        COEF_W'(((longint'(418688) << FRAC_BITS) + MICRO / 2) / MICRO);
    localparam logic [COEF_W-1:0] CF_CR_B =
        COEF_W'(((longint'(81312) << FRAC_BITS) + MICRO / 2) / MICRO);
    localparam logic [COEF_W-1:0] CF_R_CR =
        COEF_W'(((longint'(1402000) << FRAC_BITS) + MICRO / 2) / MICRO);
    localparam logic [COEF_W-1:0] CF_G_CB =
        COEF_W'(((longint'(344136) << FRAC_BITS) + MICRO / 2) / MICRO);
    localparam logic [COEF_W-1:0] CF_G_CR =
        COEF_W'(((longint'(714136) << FRAC_BITS) + MICRO / 2) / MICRO);
    localparam logic [COEF_W-1:0] CF_B_CB =
        COEF_W'(((longint'(1772000) << FRAC_BITS) + MICRO / 2) / MICRO);

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_CURVE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [Y_W-1:0]        y;
        logic signed [C_W-1:0] cb;
        logic signed [C_W-1:0] cr;
        logic [CURVE_AW-1:0]   idx;
        logic [CV_W-1:0]       val;
    } csc_t;

    typedef struct packed {
        logic                  pass;
        logic [Y_W-1:0]        y;
        logic [YC_W-1:0]       yc;
        logic signed [C_W-1:0] cb;
        logic signed [C_W-1:0] cr;
    } curve_t;

    typedef struct packed {
        logic [Y_W-1:0]        luma;
        logic signed [C_W-1:0] cb;
        logic signed [C_W-1:0] cr;
    } luma_t;

endpackage

@@ hw/rtl/ltc_csc.sv @@
module ltc_csc (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic [ltc_pkg::PIX_W-1:0]    red_in,
    input  logic [ltc_pkg::PIX_W-1:0]    green_in,
    input  logic [ltc_pkg::PIX_W-1:0]    blue_in,
    input  logic [ltc_pkg::CURVE_AW-1:0] curve_index,
    input  logic [ltc_pkg::CV_W-1:0]     curve_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ltc_pkg::csc_t                out_data
);

    localparam int PW = ltc_pkg::COEF_W + ltc_pkg::PIX_W;

    logic          vld_reg;
    ltc_pkg::csc_t csc_reg;
    ltc_pkg::csc_t csc_next;

    logic [PW-1:0]   yr, yg, yb, cbr, cbg, hb, hr, crg, crb;
    logic [PW+1:0]   y_acc;
    logic signed [PW+1:0] cb_acc;
    logic signed [PW+1:0] cr_acc;

    always_comb
    begin
        yr  = PW'(ltc_pkg::CF_Y_R) * PW'(red_in);
        yg  = PW'(ltc_pkg::CF_Y_G) * PW'(green_in);
        yb  = PW'(ltc_pkg::CF_Y_B) * PW'(blue_in);
        cbr = PW'(ltc_pkg::CF_CB_R) * PW'(red_in);
        cbg = PW'(ltc_pkg::CF_CB_G) * PW'(green_in);
        hb  = PW'(ltc_pkg::CF_HALF) * PW'(blue_in);
        hr  = PW'(ltc_pkg::CF_HALF) * PW'(red_in);
        crg = PW'(ltc_pkg::CF_CR_G) * PW'(green_in);
        crb = PW'(ltc_pkg::CF_CR_B) * PW'(blue_in);

        y_acc  = (PW+2)'(yr) + (PW+2)'(yg) + (PW+2)'(yb);
        cb_acc = $signed((PW+2)'(hb)) - $signed((PW+2)'(cbr)) - $signed((PW+2)'(cbg));
        cr_acc = $signed((PW+2)'(hr)) - $signed((PW+2)'(crg)) - $signed((PW+2)'(crb));

        csc_next.op  = ltc_pkg::op_t'(opcode);
        csc_next.y   = y_acc[ltc_pkg::Y_W-1:0];
        csc_next.cb  = $signed(cb_acc[ltc_pkg::C_W-1:0]);
        csc_next.cr  = $signed(cr_acc[ltc_pkg::C_W-1:0]);
        csc_next.idx = curve_index;
        csc_next.val = curve_value;
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = csc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            csc_reg <= csc_next;
        end
    end

endmodule

@@ hw/rtl/ltc_curve.sv @@
module ltc_curve (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ltc_pkg::csc_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ltc_pkg::curve_t out_data
);

    localparam int FB = ltc_pkg::FRAC_BITS;
    localparam int AW = ltc_pkg::CURVE_AW;
    localparam int VW = ltc_pkg::CV_W;
    localparam int SW = VW + FB + 2;

    logic [VW-1:0]            curve_mem [ltc_pkg::CURVE_ENTRIES];
    logic [ltc_pkg::CURVE_ENTRIES-1:0] ent_valid_reg;

    logic                     v2_reg, v3_reg;
    logic                     rdy2, rdy3;
    logic                     take, wr, rd;
    logic [AW-1:0]            rd_lo, rd_hi;

    logic [VW-1:0]            lo_raw_reg, hi_raw_reg;
    logic                     lo_ok_reg, hi_ok_reg;
    logic [ltc_pkg::Y_W-1:0]  y2_reg;
    logic signed [ltc_pkg::C_W-1:0] cb2_reg, cr2_reg;

    logic [AW-1:0]            seg;
    logic [FB-1:0]            frac;
    logic [VW-1:0]            lo, hi;
    logic signed [VW:0]       diff;
    logic signed [SW-1:0]     slope, base, yc_sum;
    ltc_pkg::curve_t          s3_reg;
    ltc_pkg::curve_t          s3_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;
    assign take     = in_valid && rdy2;
    assign wr       = take && (in_data.op == ltc_pkg::OP_CURVE);
    assign rd       = take && (in_data.op == ltc_pkg::OP_PIXEL);
    assign rd_lo    = in_data.y[FB +: AW];
    assign rd_hi    = rd_lo + AW'(1);

    // Curve writes are consumed here; only pixels move on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            ent_valid_reg <= '0;
        end
        else
        begin
            if (rdy2)
            begin
                v2_reg <= in_valid && (in_data.op == ltc_pkg::OP_PIXEL);
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (wr)
            begin
                ent_valid_reg[in_data.idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            curve_mem[in_data.idx] <= in_data.val;
        end
        if (rd)
        begin
            lo_raw_reg <= curve_mem[rd_lo];
            hi_raw_reg <= curve_mem[rd_hi];
            lo_ok_reg  <= ent_valid_reg[rd_lo];
            hi_ok_reg  <= ent_valid_reg[rd_hi];
            y2_reg     <= in_data.y;
            cb2_reg    <= in_data.cb;
            cr2_reg    <= in_data.cr;
        end
    end

    // Entries never written hold the identity curve.
    always_comb
    begin
        seg    = y2_reg[FB +: AW];
        frac   = y2_reg[FB-1:0];
        lo     = lo_ok_reg ? lo_raw_reg : VW'(seg);
        hi     = hi_ok_reg ? hi_raw_reg : VW'(seg) + VW'(1);
        diff   = $signed({1'b0, hi}) - $signed({1'b0, lo});
        slope  = SW'(diff) * SW'($signed({1'b0, frac}));
        base   = $signed({2'b00, lo, {FB{1'b0}}});
        yc_sum = base + slope;

        s3_next.pass = &seg;
        s3_next.y    = y2_reg;
        s3_next.yc   = yc_sum[ltc_pkg::YC_W-1:0];
        s3_next.cb   = cb2_reg;
        s3_next.cr   = cr2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

endmodule

@@ hw/rtl/ltc_gain.sv @@
module ltc_gain (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ltc_pkg::TUNE_W-1:0] tune,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ltc_pkg::curve_t            in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ltc_pkg::luma_t             out_data
);

    localparam int NS  = 5;
    localparam int P1W = ltc_pkg::YC_W + ltc_pkg::M1_W;
    localparam int P2W = ltc_pkg::BT_W + ltc_pkg::M2_W;

    typedef struct packed {
        logic                           pass;
        logic [ltc_pkg::Y_W-1:0]        y;
        logic signed [ltc_pkg::C_W-1:0] cb;
        logic signed [ltc_pkg::C_W-1:0] cr;
    } side_t;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] rdy;
    logic [NS-1:0] ld;
    side_t         side_reg [NS];

    logic [ltc_pkg::A_W-1:0]   a_reg;
    logic [ltc_pkg::YC_W-1:0]  yc_reg;
    logic [ltc_pkg::REM_W-1:0] rem_reg;
    logic [ltc_pkg::AT_W-1:0]  at1_reg, at2_reg;
    logic [ltc_pkg::BT_W-1:0]  bt_reg;
    logic [ltc_pkg::YS_W-1:0]  ysum_reg;
    logic [ltc_pkg::Y_W-1:0]   luma_reg;

    logic [P1W-1:0]            prod1;
    logic [ltc_pkg::YC_W-1:0]  a100;
    logic [P2W-1:0]            prod2;
    logic [ltc_pkg::Q2_W-1:0]  q2;
    logic [ltc_pkg::Y_W-1:0]   luma_next;

    always_comb
    begin
        rdy[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        ld[0] = rdy[0] && in_valid;
        for (int k = 1; k < NS; k++)
        begin
            ld[k] = rdy[k] && vld_reg[k-1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // floor(yc * tune / 100) = (yc / 100) * tune + floor((yc % 100) * tune / 100).
    always_comb
    begin
        prod1 = P1W'(in_data.yc) * P1W'(ltc_pkg::DIV1_MUL);
        a100  = ltc_pkg::YC_W'(a_reg) * ltc_pkg::YC_W'(100);
        prod2 = P2W'(bt_reg) * P2W'(ltc_pkg::DIV2_MUL);
        q2    = prod2[ltc_pkg::DIV2_SHIFT +: ltc_pkg::Q2_W];

        if (side_reg[3].pass)
        begin
            luma_next = (side_reg[3].y > ltc_pkg::Y_MAX) ? ltc_pkg::Y_MAX : side_reg[3].y;
        end
        else if (ysum_reg > ltc_pkg::YS_W'(ltc_pkg::Y_MAX))
        begin
            luma_next = ltc_pkg::Y_MAX;
        end
        else
        begin
            luma_next = ysum_reg[ltc_pkg::Y_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            a_reg       <= prod1[ltc_pkg::DIV1_SHIFT +: ltc_pkg::A_W];
            yc_reg      <= in_data.yc;
            side_reg[0] <= '{pass: in_data.pass, y: in_data.y, cb: in_data.cb, cr: in_data.cr};
        end
        if (ld[1])
        begin
            rem_reg     <= ltc_pkg::REM_W'(yc_reg - a100);
            at1_reg     <= ltc_pkg::AT_W'(a_reg) * ltc_pkg::AT_W'(tune);
            side_reg[1] <= side_reg[0];
        end
        if (ld[2])
        begin
            bt_reg      <= ltc_pkg::BT_W'(rem_reg) * ltc_pkg::BT_W'(tune);
            at2_reg     <= at1_reg;
            side_reg[2] <= side_reg[1];
        end
        if (ld[3])
        begin
            ysum_reg    <= ltc_pkg::YS_W'(at2_reg) + ltc_pkg::YS_W'(q2);
            side_reg[3] <= side_reg[2];
        end
        if (ld[4])
        begin
            luma_reg    <= luma_next;
            side_reg[4] <= side_reg[3];
        end
    end

    assign out_valid     = vld_reg[NS-1];
    assign out_data.luma = luma_reg;
    assign out_data.cb   = side_reg[NS-1].cb;
    assign out_data.cr   = side_reg[NS-1].cr;

endmodule

@@ hw/rtl/ltc_back.sv @@
module ltc_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  ltc_pkg::luma_t            in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ltc_pkg::PIX_W-1:0] red,
    output logic [ltc_pkg::PIX_W-1:0] green,
    output logic [ltc_pkg::PIX_W-1:0] blue
);

    localparam int NS    = 3;
    localparam int FB    = ltc_pkg::FRAC_BITS;
    localparam int YY_W  = ltc_pkg::Y_W + FB;
    localparam int P_W   = ltc_pkg::C_W + ltc_pkg::COEF_W + 1;
    localparam int BS_W  = P_W + 2;
    localparam int SHIFT = 2 * FB;
    localparam logic [BS_W-1:0] HALF    = BS_W'(1) << (SHIFT - 1);
    localparam logic [BS_W-1:0] PIX_TOP = BS_W'((1 << ltc_pkg::PIX_W) - 1);

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] rdy;
    logic [NS-1:0] ld;

    logic [YY_W-1:0]        yy_reg;
    logic signed [P_W-1:0]  pr_reg, pgb_reg, pgr_reg, pbb_reg;
    logic signed [P_W-1:0]  pr_next, pgb_next, pgr_next, pbb_next;
    logic signed [BS_W-1:0] vr_reg, vg_reg, vb_reg;
    logic signed [BS_W-1:0] yys;
    logic [ltc_pkg::PIX_W-1:0] red_reg, green_reg, blue_reg;

    logic signed [ltc_pkg::COEF_W:0] k_r_cr, k_g_cb, k_g_cr, k_b_cb;

    // Round half away from zero, then clip; a negative sum always ends at zero.
    function automatic logic [ltc_pkg::PIX_W-1:0] round_clip(input logic signed [BS_W-1:0] v);
        logic [BS_W-1:0] t;
        logic [BS_W-1:0] q;
        t = $unsigned(v) + HALF;
        q = t >> SHIFT;
        if (v < 0)
        begin
            return '0;
        end
        else if (q > PIX_TOP)
        begin
            return PIX_TOP[ltc_pkg::PIX_W-1:0];
        end
        return q[ltc_pkg::PIX_W-1:0];
    endfunction

    always_comb
    begin
        rdy[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        ld[0] = rdy[0] && in_valid;
        for (int k = 1; k < NS; k++)
        begin
            ld[k] = rdy[k] && vld_reg[k-1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        k_r_cr   = $signed({1'b0, ltc_pkg::CF_R_CR});
        k_g_cb   = $signed({1'b0, ltc_pkg::CF_G_CB});
        k_g_cr   = $signed({1'b0, ltc_pkg::CF_G_CR});
        k_b_cb   = $signed({1'b0, ltc_pkg::CF_B_CB});
        pr_next  = P_W'(in_data.cr) * P_W'(k_r_cr);
        pgb_next = P_W'(in_data.cb) * P_W'(k_g_cb);
        pgr_next = P_W'(in_data.cr) * P_W'(k_g_cr);
        pbb_next = P_W'(in_data.cb) * P_W'(k_b_cb);
        yys      = $signed({{(BS_W - YY_W){1'b0}}, yy_reg});
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            yy_reg  <= {in_data.luma, {FB{1'b0}}};
            pr_reg  <= pr_next;
            pgb_reg <= pgb_next;
            pgr_reg <= pgr_next;
            pbb_reg <= pbb_next;
        end
        if (ld[1])
        begin
            vr_reg <= yys + BS_W'(pr_reg);
            vg_reg <= yys - BS_W'(pgb_reg) - BS_W'(pgr_reg);
            vb_reg <= yys + BS_W'(pbb_reg);
        end
        if (ld[2])
        begin
            red_reg   <= round_clip(vr_reg);
            green_reg <= round_clip(vg_reg);
            blue_reg  <= round_clip(vb_reg);
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

@@ hw/rtl/luma_tone_curve_mapper_top.sv @@
// Pixel path: 11 register stages. Throughput: one transfer per cycle while the output is not
// back-pressured; every stage holds a valid bit, so bubbles close up under output back-pressure.
// Curve writes produce no result and take effect in stage 2, before any later pixel
// reads the curve.
// Reset: pipeline empty, tune_percent = 100, curve = identity via per-entry
// written bits (no clearing pass).
module luma_tone_curve_mapper_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic [ltc_pkg::PIX_W-1:0]    red_in,
    input  logic [ltc_pkg::PIX_W-1:0]    green_in,
    input  logic [ltc_pkg::PIX_W-1:0]    blue_in,
    input  logic [ltc_pkg::CURVE_AW-1:0] curve_index,
    input  logic [ltc_pkg::CV_W-1:0]     curve_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ltc_pkg::PIX_W-1:0]    red_out,
    output logic [ltc_pkg::PIX_W-1:0]    green_out,
    output logic [ltc_pkg::PIX_W-1:0]    blue_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam logic REG_TUNE = 1'b0;
    localparam logic [ltc_pkg::TUNE_W-1:0] TUNE_RESET = ltc_pkg::TUNE_W'(100);

    logic [ltc_pkg::TUNE_W-1:0] tune_percent_reg;
    logic                       cfg_wr;

    logic            csc_valid, csc_ready;
    ltc_pkg::csc_t   csc_data;
    logic            crv_valid, crv_ready;
    ltc_pkg::curve_t crv_data;
    logic            gain_valid, gain_ready;
    ltc_pkg::luma_t  gain_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TUNE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tune_percent_reg <= TUNE_RESET;
        end
        else if (cfg_wr)
        begin
            tune_percent_reg <= pwdata[ltc_pkg::TUNE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_TUNE: prdata = 32'(tune_percent_reg);
            default:  prdata = '0;
        endcase
    end

    ltc_csc u_csc (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .curve_index (curve_index),
        .curve_value (curve_value),
        .out_valid   (csc_valid),
        .out_ready   (csc_ready),
        .out_data    (csc_data)
    );

    ltc_curve u_curve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (csc_valid),
        .in_ready  (csc_ready),
        .in_data   (csc_data),
        .out_valid (crv_valid),
        .out_ready (crv_ready),
        .out_data  (crv_data)
    );

    ltc_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .tune      (tune_percent_reg),
        .in_valid  (crv_valid),
        .in_ready  (crv_ready),
        .in_data   (crv_data),
        .out_valid (gain_valid),
        .out_ready (gain_ready),
        .out_data  (gain_data)
    );

    ltc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (gain_valid),
        .in_ready  (gain_ready),
        .in_data   (gain_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red_out),
        .green     (green_out),
        .blue      (blue_out)
    );

    // The input side only stalls when every stage is full and the output is blocked.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while the pipeline had a free stage");

    // A register write lands in the gain register on the following cycle.
    a_tune_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (tune_percent_reg == $past(pwdata[ltc_pkg::TUNE_W-1:0])))
        else $error("tune_percent write was not taken");

    // A curve write at the output of the first stage never reaches the gain stages.
    a_write_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (csc_valid && csc_ready && (csc_data.op == ltc_pkg::OP_CURVE) && crv_ready)
        |=> !$past(crv_valid && !crv_ready) || crv_valid)
        else $error("curve write disturbed the pixel stream");

endmodule

@@ tb/luma_tone_curve_mapper_top_test.sv @@
`timescale 1ns / 100ps

module luma_tone_curve_mapper_top_test;

    localparam int     FRAC       = ltc_pkg::FRAC_BITS;
    localparam longint ONE        = longint'(1) << FRAC;
    localparam longint LUMA_MAX   = 255 * ONE;
    localparam longint ROUND_HALF = longint'(1) << (2 * FRAC - 1);
    localparam logic [2:0] REG_TUNE_ADDR = 3'd0;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [ltc_pkg::PIX_W-1:0] red;
        logic [ltc_pkg::PIX_W-1:0] green;
        logic [ltc_pkg::PIX_W-1:0] blue;
    } rgb_t;

    function automatic longint fixed_coef(input longint micro);
        return ((micro << FRAC) + 500000) / 1000000;
    endfunction

    localparam longint K_Y_R  = fixed_coef(299000);
    localparam longint K_Y_G  = fixed_coef(587000);
    localparam longint K_Y_B  = fixed_coef(114000);
    localparam longint K_CB_R = fixed_coef(168736);
    localparam longint K_CB_G = fixed_coef(331264);
    localparam longint K_HALF = fixed_coef(500000);
    localparam longint K_CR_G = fixed_coef(418688);
    localparam longint K_CR_B = fixed_coef(81312);
    localparam longint K_R_CR = fixed_coef(1402000);
    localparam longint K_G_CB = fixed_coef(344136);
    localparam longint K_G_CR = fixed_coef(714136);
    localparam longint K_B_CB = fixed_coef(1772000);

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           opcode = ltc_pkg::OP_PIXEL;
    logic [ltc_pkg::PIX_W-1:0]      red_in = '0;
    logic [ltc_pkg::PIX_W-1:0]      green_in = '0;
    logic [ltc_pkg::PIX_W-1:0]      blue_in = '0;
    logic [ltc_pkg::CURVE_AW-1:0]   curve_index = '0;
    logic [ltc_pkg::CV_W-1:0]       curve_value = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b1;
    logic [ltc_pkg::PIX_W-1:0]      red_out;
    logic [ltc_pkg::PIX_W-1:0]      green_out;
    logic [ltc_pkg::PIX_W-1:0]      blue_out;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [2:0]                     paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    // Shadow copy of the block's state, updated in transfer order.
    logic [ltc_pkg::CV_W-1:0] curve_shadow [0:ltc_pkg::CURVE_ENTRIES-1];
    longint                   tune_shadow;

    rgb_t expected_pixels[$];
    int   error_count = 0;
    bit   no_idle = 1'b0;
    int   stall_left = 0;

    luma_tone_curve_mapper_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .curve_index (curve_index),
        .curve_value (curve_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ltc_pkg::PIX_W-1:0] round_clamp(input longint v);
        longint r;
        if (v >= 0)
            r = (v + ROUND_HALF) >>> (2 * FRAC);
        else
            r = -((-v + ROUND_HALF) >>> (2 * FRAC));
        if (r < 0)
            r = 0;
        if (r > 255)
            r = 255;
        return r[ltc_pkg::PIX_W-1:0];
    endfunction

    function automatic rgb_t tone_map_pixel(input logic [ltc_pkg::PIX_W-1:0] r8, g8, b8);
        longint r, g, b, luma, cb, cr, seg, frac, lo, hi, yc, prod;
        rgb_t res;
        r = longint'(r8);
        g = longint'(g8);
        b = longint'(b8);
        luma = K_Y_R * r + K_Y_G * g + K_Y_B * b;
        cb = K_HALF * b - K_CB_R * r - K_CB_G * g;
        cr = K_HALF * r - K_CR_G * g - K_CR_B * b;
        seg = luma >>> FRAC;
        frac = luma & (ONE - 1);
        // The top luma segment has no upper neighbor, so it bypasses curve and gain.
        if (seg < 255)
        begin
            lo = longint'(curve_shadow[seg]);
            hi = longint'(curve_shadow[seg + 1]);
            yc = lo * ONE + (hi - lo) * frac;
            prod = yc * tune_shadow;
            if (prod < 0)
                prod = 0;
            luma = prod / 100;
        end
        if (luma < 0)
            luma = 0;
        if (luma > LUMA_MAX)
            luma = LUMA_MAX;
        luma = luma * ONE;
        res.red   = round_clamp(luma + K_R_CR * cr);
        res.green = round_clamp(luma - K_G_CB * cb - K_G_CR * cr);
        res.blue  = round_clamp(luma + K_B_CB * cb);
        return res;
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: r=%0d g=%0d b=%0d",
                             red_out, green_out, blue_out);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (red_out !== want.red || green_out !== want.green
                    || blue_out !== want.blue)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want.red, want.green, want.blue,
                                 red_out, green_out, blue_out);
                end
            end
        end
    end

    // Output back-pressure: ready runs alternate with stall bursts, but ready stays high while no_idle is set.
    always @(negedge clk)
    begin
        if (no_idle)
            out_ready = 1'b1;
        else if (stall_left > 0)
            stall_left--;
        else if (out_ready)
        begin
            out_ready = 1'b0;
            stall_left = int'($urandom_range(0, 13));
        end
        else
        begin
            out_ready = 1'b1;
            stall_left = int'($urandom_range(0, 39));
        end
    end

    task automatic send_item(input ltc_pkg::op_t op,
                             input logic [ltc_pkg::PIX_W-1:0] r, g, b,
                             input logic [ltc_pkg::CURVE_AW-1:0] idx,
                             input logic [ltc_pkg::CV_W-1:0] val);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 5) == 0)
            gap = int'($urandom_range(1, 14));
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode = op;
        red_in = r;
        green_in = g;
        blue_in = b;
        curve_index = idx;
        curve_value = val;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (op == ltc_pkg::OP_CURVE)
            curve_shadow[idx] = val;
        else
            expected_pixels.push_back(tone_map_pixel(r, g, b));
    endtask

    // Write fields carry random junk on a pixel, and pixel fields on a curve write.
    task automatic send_pixel(input logic [ltc_pkg::PIX_W-1:0] r, g, b);
        send_item(ltc_pkg::OP_PIXEL, r, g, b,
                  ltc_pkg::CURVE_AW'($urandom), ltc_pkg::CV_W'($urandom));
    endtask

    task automatic send_curve(input logic [ltc_pkg::CURVE_AW-1:0] idx,
                              input logic [ltc_pkg::CV_W-1:0] val);
        send_item(ltc_pkg::OP_CURVE, ltc_pkg::PIX_W'($urandom), ltc_pkg::PIX_W'($urandom),
                  ltc_pkg::PIX_W'($urandom), idx, val);
    endtask

    // Stops input and waits until all pixels are back and any curve write has landed.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tune(input logic [ltc_pkg::TUNE_W-1:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = REG_TUNE_ADDR;
        pwdata = 32'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tune_shadow = longint'(value);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_tune_readback();
        logic [31:0] got;
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b0;
        paddr = REG_TUNE_ADDR;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (got !== 32'(tune_shadow))
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("tune readback mismatch: expected %0d got %0d", tune_shadow, got);
        end
    endtask

    task automatic set_tune(input logic [ltc_pkg::TUNE_W-1:0] value);
        drain_pipeline();
        write_tune(value);
        check_tune_readback();
    endtask

    // Identity curve and unit gain straight out of reset.
    task automatic test_reset_state();
        check_tune_readback();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_item(ltc_pkg::OP_PIXEL, 8'd10, 8'd200, 8'd77, 8'd255, 9'd511);
    endtask

    // Curve edits at both ends, out-of-range values, and the white bypass.
    task automatic test_curve_edits();
        send_curve(8'd0, 9'd256);
        send_curve(8'd1, 9'd0);
        send_curve(8'd255, 9'd511);
        send_curve(8'd254, 9'd300);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd254, 8'd254, 8'd254);
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd255, 8'd255, 8'd255);
    endtask

    task automatic test_gain_extremes();
        set_tune(9'd0);
        send_pixel(8'd200, 8'd60, 8'd30);
        set_tune(9'd511);
        send_pixel(8'd90, 8'd100, 8'd110);
        set_tune(9'd1);
        send_pixel(8'd250, 8'd240, 8'd230);
        set_tune(9'd300);
        send_pixel(8'd40, 8'd180, 8'd220);
    endtask

    task automatic send_random_item();
        logic [ltc_pkg::PIX_W-1:0] r, g, b;
        logic [ltc_pkg::CV_W-1:0] val;
        int mode;
        if ($urandom_range(0, 4) == 0)
        begin
            val = ($urandom_range(0, 9) == 0) ? ltc_pkg::CV_W'($urandom_range(257, 511))
                                              : ltc_pkg::CV_W'($urandom_range(0, 256));
            send_curve(ltc_pkg::CURVE_AW'($urandom), val);
        end
        else
        begin
            mode = int'($urandom_range(0, 9));
            r = ltc_pkg::PIX_W'($urandom);
            g = ltc_pkg::PIX_W'($urandom);
            b = ltc_pkg::PIX_W'($urandom);
            if (mode == 0)
            begin
                r = {ltc_pkg::PIX_W{r[0]}};
                g = {ltc_pkg::PIX_W{g[0]}};
                b = {ltc_pkg::PIX_W{b[0]}};
            end
            else if (mode == 1)
            begin
                g = r;
                b = r;
            end
            send_pixel(r, g, b);
        end
    endtask

    // Random mix of pixels and curve writes over several gain settings;
    // the last phase runs with no idling on either side.
    task automatic test_random_stream();
        int phase;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_tune(9'd100);
                2: set_tune(9'd300);
                4: set_tune(ltc_pkg::TUNE_W'($urandom_range(50, 200)));
                default: set_tune(ltc_pkg::TUNE_W'($urandom_range(1, 300)));
            endcase
            if (phase == 4)
                no_idle = 1'b1;
            repeat (220) send_random_item();
        end
    endtask

    initial
    begin
        for (int i = 0; i < ltc_pkg::CURVE_ENTRIES; i++)
            curve_shadow[i] = ltc_pkg::CV_W'(i);
        tune_shadow = 100;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_curve_edits();
        test_gain_extremes();
        test_random_stream();

        drain_pipeline();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("luma_tone_curve_mapper_top regression: pass");
        else
            $display("luma_tone_curve_mapper_top regression: fail");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("luma_tone_curve_mapper_top regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ltc_pkg.sv
hw/rtl/ltc_csc.sv
hw/rtl/ltc_curve.sv
hw/rtl/ltc_gain.sv
hw/rtl/ltc_back.sv
hw/rtl/luma_tone_curve_mapper_top.sv
tb/luma_tone_curve_mapper_top_test.sv
